// File: hw/rtl/mcpg_pkg.sv
// Shared constants and types for the midpoint circle pixel generator.
`timescale 1ns / 1ps

package mcpg_pkg;

  // Coordinate width of center, radius and offsets.
  localparam int COORD_BITS_DEF = 11;

  // Generated point coordinates, two's complement.
  localparam int PIX_BITS = 13;
  localparam int VALUE_BITS = 8;
  localparam int DEPTH_BITS = 8;

  // Result payload: pixel_x, pixel_y, out_value, out_depth, padded to bytes.
  localparam int OUT_FIELD_BITS = 2 * PIX_BITS + VALUE_BITS + DEPTH_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_PAD_BITS = OUT_TDATA_BITS - OUT_FIELD_BITS;

  // Jobs held between the front and back halves.
  localparam int QUEUE_DEPTH = 2;

  // Points emitted per job.
  localparam int POINTS_PER_STEP = 8;
  localparam int POINT_IDX_BITS = $clog2(POINTS_PER_STEP);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

endpackage

// File: hw/rtl/midpoint_circle_pixel_generator_top.sv
// Top level of the midpoint circle pixel generator.
//
//   channel  | dir | payload                                         | frame
//   s_axis   | in  | tuser: command                                  | none
//            |     | tdata: center_x, center_y, radius, value, depth |
//   m_axis   | out | tdata: pixel_x, pixel_y, out_value, out_depth   | tlast: last_of_step
//            |     | tuser: last_of_circle                           |
//
// Each start or step produces eight points, one per cycle from the output
// register while m_tready is high; the front updates the decision term and
// hands the job to a two-entry queue. A step while idle is taken and produces
// nothing. Reset clears the circle state and empties queue and output register.
// The input stalls only when the queue is full.
`timescale 1ns / 1ps

module midpoint_circle_pixel_generator_top #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // center_x, center_y, radius, pixel_value, pixel_depth, zero pad
  input  logic [((3 * COORD_BITS + mcpg_pkg::VALUE_BITS + mcpg_pkg::DEPTH_BITS + 7) / 8)
                * 8 - 1:0]                    s_tdata,
  // command
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x, pixel_y, out_value, out_depth, zero pad
  output logic [mcpg_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  output logic                                m_tlast,
  // last_of_circle
  output logic                                m_tuser
);

  localparam int CB = COORD_BITS;
  localparam int VB = mcpg_pkg::VALUE_BITS;
  localparam int DB = mcpg_pkg::DEPTH_BITS;
  localparam int JOB_BITS = 4 * CB + VB + DB + 1;

  logic                          f_valid;
  logic                          f_ready;
  logic [CB-1:0]                 f_cx;
  logic [CB-1:0]                 f_cy;
  logic [CB-1:0]                 f_x;
  logic [CB-1:0]                 f_y;
  logic [VB-1:0]                 f_value;
  logic [DB-1:0]                 f_depth;
  logic                          f_done;
  logic                          b_valid;
  logic                          b_ready;
  logic [JOB_BITS-1:0]           q_in;
  logic [JOB_BITS-1:0]           q_out;
  logic [mcpg_pkg::PIX_BITS-1:0] pixel_x;
  logic [mcpg_pkg::PIX_BITS-1:0] pixel_y;
  logic [VB-1:0]                 out_value;
  logic [DB-1:0]                 out_depth;

  mcpg_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .command     (mcpg_pkg::cmd_t'(s_tuser)),
    .center_x    (s_tdata[CB-1:0]),
    .center_y    (s_tdata[2*CB-1:CB]),
    .radius      (s_tdata[3*CB-1:2*CB]),
    .pixel_value (s_tdata[3*CB+VB-1:3*CB]),
    .pixel_depth (s_tdata[3*CB+VB+DB-1:3*CB+VB]),
    .job_valid   (f_valid),
    .job_ready   (f_ready),
    .job_cx      (f_cx),
    .job_cy      (f_cy),
    .job_x       (f_x),
    .job_y       (f_y),
    .job_value   (f_value),
    .job_depth   (f_depth),
    .job_done    (f_done)
  );

  assign q_in = {f_done, f_depth, f_value, f_y, f_x, f_cy, f_cx};

  mcpg_queue #(
    .WIDTH(JOB_BITS),
    .DEPTH(mcpg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (q_in),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (q_out)
  );

  mcpg_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (b_valid),
    .job_ready      (b_ready),
    .job_cx         (q_out[CB-1:0]),
    .job_cy         (q_out[2*CB-1:CB]),
    .job_x          (q_out[3*CB-1:2*CB]),
    .job_y          (q_out[4*CB-1:3*CB]),
    .job_value      (q_out[4*CB+VB-1:4*CB]),
    .job_depth      (q_out[4*CB+VB+DB-1:4*CB+VB]),
    .job_done       (q_out[JOB_BITS-1]),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .out_value      (out_value),
    .out_depth      (out_depth),
    .last_of_step   (m_tlast),
    .last_of_circle (m_tuser)
  );

  assign m_tdata = {{mcpg_pkg::OUT_PAD_BITS{1'b0}}, out_depth, out_value, pixel_y, pixel_x};

endmodule

// File: hw/rtl/mcpg_front.sv
// Front half: accepts commands, runs the midpoint decision update, issues jobs.
`timescale 1ns / 1ps

module mcpg_front #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mcpg_pkg::cmd_t                  command,
  input  logic [COORD_BITS-1:0]           center_x,
  input  logic [COORD_BITS-1:0]           center_y,
  input  logic [COORD_BITS-1:0]           radius,
  input  logic [mcpg_pkg::VALUE_BITS-1:0] pixel_value,
  input  logic [mcpg_pkg::DEPTH_BITS-1:0] pixel_depth,
  output logic                            job_valid,
  input  logic                            job_ready,
  output logic [COORD_BITS-1:0]           job_cx,
  output logic [COORD_BITS-1:0]           job_cy,
  output logic [COORD_BITS-1:0]           job_x,
  output logic [COORD_BITS-1:0]           job_y,
  output logic [mcpg_pkg::VALUE_BITS-1:0] job_value,
  output logic [mcpg_pkg::DEPTH_BITS-1:0] job_depth,
  output logic                            job_done
);

  localparam int DEC_BITS = COORD_BITS + 3;

  logic                            active;
  logic [COORD_BITS-1:0]           offset_x;
  logic [COORD_BITS-1:0]           offset_y;
  logic [DEC_BITS-1:0]             decision;
  logic [COORD_BITS-1:0]           saved_center_x;
  logic [COORD_BITS-1:0]           saved_center_y;
  logic [mcpg_pkg::VALUE_BITS-1:0] saved_value;
  logic [mcpg_pkg::DEPTH_BITS-1:0] saved_depth;

  logic                  accept;
  logic                  is_start;
  logic [COORD_BITS-1:0] offset_x_next;
  logic [COORD_BITS-1:0] offset_y_next;
  logic [DEC_BITS-1:0]   decision_next;
  logic [DEC_BITS-1:0]   x_ext;
  logic [DEC_BITS-1:0]   y_ext;

  assign in_ready = job_ready;
  assign accept   = in_valid && in_ready;
  assign is_start = (command == mcpg_pkg::CMD_START);

  assign x_ext = DEC_BITS'(offset_x);
  assign y_ext = DEC_BITS'(offset_y);

  always_comb begin
    if (is_start) begin
      offset_x_next = '0;
      offset_y_next = radius;
      decision_next = DEC_BITS'(1) - DEC_BITS'(radius);
    end else if (decision[DEC_BITS-1]) begin
      offset_x_next = offset_x + COORD_BITS'(1);
      offset_y_next = offset_y;
      decision_next = decision + (x_ext << 1) + DEC_BITS'(3);
    end else begin
      offset_x_next = offset_x + COORD_BITS'(1);
      offset_y_next = offset_y - COORD_BITS'(1);
      decision_next = decision + ((x_ext - y_ext) << 1) + DEC_BITS'(5);
    end
  end

  // A step while idle is taken and dropped.
  assign job_valid = in_valid && (is_start || active);
  assign job_cx    = is_start ? center_x : saved_center_x;
  assign job_cy    = is_start ? center_y : saved_center_y;
  assign job_value = is_start ? pixel_value : saved_value;
  assign job_depth = is_start ? pixel_depth : saved_depth;
  assign job_x     = offset_x_next;
  assign job_y     = offset_y_next;
  assign job_done  = (offset_y_next <= offset_x_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      offset_x       <= '0;
      offset_y       <= '0;
      decision       <= '0;
      saved_center_x <= '0;
      saved_center_y <= '0;
      saved_value    <= '0;
      saved_depth    <= '0;
    end else if (accept && (is_start || active)) begin
      offset_x <= offset_x_next;
      offset_y <= offset_y_next;
      decision <= decision_next;
      active   <= !job_done;
      if (is_start) begin
        saved_center_x <= center_x;
        saved_center_y <= center_y;
        saved_value    <= pixel_value;
        saved_depth    <= pixel_depth;
      end
    end
  end

endmodule

// File: hw/rtl/mcpg_queue.sv
// Short job queue between the front and back halves.
`timescale 1ns / 1ps

module mcpg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = mcpg_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push;
  logic                pop;

  assign wr_ready = (count != CNT_BITS'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - CNT_BITS'(1);
      end
    end
  end

endmodule

// File: hw/rtl/mcpg_back.sv
// Back half: walks the eight octant points of a job into the output register.
`timescale 1ns / 1ps

module mcpg_back #(
  parameter int COORD_BITS = mcpg_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  input  logic [COORD_BITS-1:0]               job_cx,
  input  logic [COORD_BITS-1:0]               job_cy,
  input  logic [COORD_BITS-1:0]               job_x,
  input  logic [COORD_BITS-1:0]               job_y,
  input  logic [mcpg_pkg::VALUE_BITS-1:0]     job_value,
  input  logic [mcpg_pkg::DEPTH_BITS-1:0]     job_depth,
  input  logic                                job_done,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mcpg_pkg::PIX_BITS-1:0]       pixel_x,
  output logic [mcpg_pkg::PIX_BITS-1:0]       pixel_y,
  output logic [mcpg_pkg::VALUE_BITS-1:0]     out_value,
  output logic [mcpg_pkg::DEPTH_BITS-1:0]     out_depth,
  output logic                                last_of_step,
  output logic                                last_of_circle
);

  localparam int SUM_BITS = (COORD_BITS + 2 > mcpg_pkg::PIX_BITS) ?
                            COORD_BITS + 2 : mcpg_pkg::PIX_BITS;
  localparam int IDX_BITS = mcpg_pkg::POINT_IDX_BITS;

  logic                            held;
  logic [IDX_BITS-1:0]             idx;
  logic [COORD_BITS-1:0]           cur_cx;
  logic [COORD_BITS-1:0]           cur_cy;
  logic [COORD_BITS-1:0]           cur_x;
  logic [COORD_BITS-1:0]           cur_y;
  logic [mcpg_pkg::VALUE_BITS-1:0] cur_value;
  logic [mcpg_pkg::DEPTH_BITS-1:0] cur_depth;
  logic                            cur_done;

  logic                  out_adv;
  logic                  emit;
  logic                  last_idx;
  logic [COORD_BITS-1:0] off_a;
  logic [COORD_BITS-1:0] off_b;
  logic [SUM_BITS-1:0]   sum_x;
  logic [SUM_BITS-1:0]   sum_y;

  assign out_adv   = !out_valid || out_ready;
  assign emit      = held && out_adv;
  assign last_idx  = (idx == IDX_BITS'(mcpg_pkg::POINTS_PER_STEP - 1));
  assign job_ready = !held || (emit && last_idx);

  // Upper half of the sequence swaps x and y; idx[1] negates the column
  // offset, idx[0] the row offset.
  assign off_a = idx[2] ? cur_y : cur_x;
  assign off_b = idx[2] ? cur_x : cur_y;

  always_comb begin
    if (idx[1]) begin
      sum_x = SUM_BITS'(cur_cx) - SUM_BITS'(off_a);
    end else begin
      sum_x = SUM_BITS'(cur_cx) + SUM_BITS'(off_a);
    end
    if (idx[0]) begin
      sum_y = SUM_BITS'(cur_cy) - SUM_BITS'(off_b);
    end else begin
      sum_y = SUM_BITS'(cur_cy) + SUM_BITS'(off_b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      idx  <= '0;
    end else begin
      if (job_valid && job_ready) begin
        held <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        idx <= idx + IDX_BITS'(1);
        if (last_idx) begin
          held <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) begin
      cur_cx    <= job_cx;
      cur_cy    <= job_cy;
      cur_x     <= job_x;
      cur_y     <= job_y;
      cur_value <= job_value;
      cur_depth <= job_depth;
      cur_done  <= job_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x        <= sum_x[mcpg_pkg::PIX_BITS-1:0];
      pixel_y        <= sum_y[mcpg_pkg::PIX_BITS-1:0];
      out_value      <= cur_value;
      out_depth      <= cur_depth;
      last_of_step   <= last_idx;
      last_of_circle <= last_idx && cur_done;
    end
  end

endmodule

// File: hw/rtl/mcpg_checker.sv
// Port-level checks on the pixel stream of the circle generator, with bind.
`timescale 1ns / 1ps

module mcpg_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [mcpg_pkg::OUT_TDATA_BITS-1:0] m_tdata,
  input logic                                m_tlast,
  input logic                                m_tuser
);

  // The end of a circle is only flagged on the closing point of a step.
  a_circle_end_on_step_end: assert property (
    @(posedge clk) disable iff (rst) m_tvalid |-> (!m_tuser || m_tlast)
  ) else $error("last_of_circle without last_of_step");

  // Points of one step follow each other with no gap.
  a_step_no_gap: assert property (
    @(posedge clk) disable iff (rst) (m_tvalid && m_tready && !m_tlast) |=> m_tvalid
  ) else $error("gap inside the eight points of a step");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (
    @(posedge clk) rst |=> !m_tvalid
  ) else $error("output valid right after reset");

  // Hold a stalled transfer.
  a_stall_hold: assert property (
    @(posedge clk) disable iff (rst) (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
  ) else $error("stalled output changed");

endmodule

bind midpoint_circle_pixel_generator_top mcpg_checker u_mcpg_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

// File: test/testbench.sv
// Self-checking testbench for the midpoint circle pixel generator.
`timescale 1ns / 1ps

module testbench;

  localparam int CB = mcpg_pkg::COORD_BITS_DEF;
  localparam int PB = mcpg_pkg::PIX_BITS;
  localparam int IN_TDATA_BITS =
    ((3 * CB + mcpg_pkg::VALUE_BITS + mcpg_pkg::DEPTH_BITS + 7) / 8) * 8;
  localparam int RANDOM_ITEMS = 360;
  localparam int PHASE_ITEMS = 90;
  localparam int DIR_ROWS = 25;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    mcpg_pkg::cmd_t   cmd;
    logic [CB-1:0]    cx;
    logic [CB-1:0]    cy;
    logic [CB-1:0]    r;
    logic [7:0]       val;
    logic [7:0]       dep;
  } circle_cmd_t;

  typedef struct {
    logic [PB-1:0] px;
    logic [PB-1:0] py;
    logic [7:0]    val;
    logic [7:0]    dep;
    logic          lstep;
    logic          lcircle;
  } pixel_point_t;

  // n_pts < 0: rely on the predictor alone; otherwise count and first point are known
  typedef struct {
    circle_cmd_t   item;
    int            n_pts;
    logic [PB-1:0] fx;
    logic [PB-1:0] fy;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_BITS-1:0] s_tdata = '0;
  logic s_tuser = mcpg_pkg::CMD_STEP;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mcpg_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  midpoint_circle_pixel_generator_top #(
    .COORD_BITS(CB)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #10 clk = ~clk;

  // Circle tracker state
  logic [CB-1:0]          off_x = '0;
  logic [CB-1:0]          off_y = '0;
  logic signed [CB+2:0]   dec_q = '0;
  logic [CB-1:0]          ctr_x = '0;
  logic [CB-1:0]          ctr_y = '0;
  logic [7:0]             lat_value = '0;
  logic [7:0]             lat_depth = '0;
  bit                     circle_busy = 1'b0;

  pixel_point_t pixel_q[$];
  pixel_point_t lead_pt;
  int emitting_items = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic void push_point(logic [PB-1:0] px, logic [PB-1:0] py,
                                     logic lstep, logic lcircle);
    pixel_point_t p;
    p.px = px;
    p.py = py;
    p.val = lat_value;
    p.dep = lat_depth;
    p.lstep = lstep;
    p.lcircle = lcircle;
    pixel_q.push_back(p);
  endfunction

  function automatic void push_octants();
    logic [PB-1:0] cx, cy, x, y;
    logic done;
    cx = PB'(ctr_x);
    cy = PB'(ctr_y);
    x = PB'(off_x);
    y = PB'(off_y);
    done = (off_y <= off_x);
    push_point(cx + x, cy + y, 1'b0, 1'b0);
    lead_pt = pixel_q[pixel_q.size() - 1];
    push_point(cx + x, cy - y, 1'b0, 1'b0);
    push_point(cx - x, cy + y, 1'b0, 1'b0);
    push_point(cx - x, cy - y, 1'b0, 1'b0);
    push_point(cx + y, cy + x, 1'b0, 1'b0);
    push_point(cx + y, cy - x, 1'b0, 1'b0);
    push_point(cx - y, cy + x, 1'b0, 1'b0);
    push_point(cx - y, cy - x, 1'b1, done);
    if (done) circle_busy = 1'b0;
  endfunction

  // Advance the tracker by one accepted command; return the number of points queued.
  function automatic int rasterize_item(circle_cmd_t c);
    if (c.cmd == mcpg_pkg::CMD_START) begin
      ctr_x = c.cx;
      ctr_y = c.cy;
      lat_value = c.val;
      lat_depth = c.dep;
      off_x = '0;
      off_y = c.r;
      dec_q = (CB+3)'(1 - int'(c.r));
      circle_busy = 1'b1;
    end else begin
      if (!circle_busy) return 0;
      if (dec_q < 0) begin
        dec_q = (CB+3)'(int'(dec_q) + 2 * int'(off_x) + 3);
      end else begin
        dec_q = (CB+3)'(int'(dec_q) + 2 * (int'(off_x) - int'(off_y)) + 5);
        off_y = off_y - CB'(1);
      end
      off_x = off_x + CB'(1);
    end
    push_octants();
    emitting_items++;
    return mcpg_pkg::POINTS_PER_STEP;
  endfunction

  function automatic circle_cmd_t rand_item(mcpg_pkg::cmd_t c, int r);
    circle_cmd_t it;
    it.cmd = c;
    it.cx = CB'($urandom_range((1 << CB) - 1));
    it.cy = CB'($urandom_range((1 << CB) - 1));
    it.r = CB'(r);
    it.val = 8'($urandom_range(255));
    it.dep = 8'($urandom_range(255));
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input circle_cmd_t c, output int n_pts);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= c.cmd;
    s_tdata <= IN_TDATA_BITS'({c.dep, c.val, c.r, c.cy, c.cx});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_pts = rasterize_item(c);
    @(negedge clk);
  endtask

  task automatic drain_and_switch(int phase);
    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    @(negedge clk);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  always @(negedge clk) begin
    m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin : pixel_check
    pixel_point_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected pixel transfer: tdata=%h tlast=%b tuser=%b",
               m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = pixel_q.pop_front();
        if (m_tdata[PB-1:0] !== want.px) begin
          $error("pixel_x: expected %0d, got %0d", $signed(want.px),
                 $signed(m_tdata[PB-1:0]));
          errors++;
        end
        if (m_tdata[2*PB-1:PB] !== want.py) begin
          $error("pixel_y: expected %0d, got %0d", $signed(want.py),
                 $signed(m_tdata[2*PB-1:PB]));
          errors++;
        end
        if (m_tdata[2*PB+7:2*PB] !== want.val) begin
          $error("out_value: expected %0d, got %0d", want.val,
                 m_tdata[2*PB+7:2*PB]);
          errors++;
        end
        if (m_tdata[2*PB+15:2*PB+8] !== want.dep) begin
          $error("out_depth: expected %0d, got %0d", want.dep,
                 m_tdata[2*PB+15:2*PB+8]);
          errors++;
        end
        if (m_tlast !== want.lstep) begin
          $error("last_of_step: expected %0b, got %0b", want.lstep, m_tlast);
          errors++;
        end
        if (m_tuser !== want.lcircle) begin
          $error("last_of_circle: expected %0b, got %0b", want.lcircle, m_tuser);
          errors++;
        end
      end
    end
  end

  stim_row_t dir_tab [0:DIR_ROWS-1];

  initial begin
    int n;
    int phase;
    int limit;
    int steps;
    int roll;
    int r;
    circle_cmd_t it;

    dir_tab = '{
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, 0, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, 8, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd2047, 11'd2047, 11'd2047, 8'hFF, 8'hFF}, 0, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd2047, 11'd2047, 11'd2047, 8'hFF, 8'hFF}, 8, 13'd2047,
        13'd4094},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd2047, 11'd2047, 11'd2047, 8'hFF, 8'hFF}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd0, 11'd0, 11'd2047, 8'hA5, 8'h5A}, 8, 13'd0, 13'd2047},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd100, 11'd200, 11'd1, 8'h3C, 8'hC3}, 8, 13'd100, 13'd201},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, 0, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd1024, 11'd1024, 11'd2, 8'h55, 8'hAA}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd5, 11'd9, 11'd3, 8'h01, 8'h80}, 8, 13'd5, 13'd12},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_START, 11'd2047, 11'd0, 11'd10, 8'h7F, 8'hFE}, 8, 13'd2047, 13'd10},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0},
      '{'{mcpg_pkg::CMD_STEP, 11'd0, 11'd0, 11'd0, 8'h00, 8'h00}, -1, 13'd0, 13'd0}
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_tab[i].item, n);
      if (dir_tab[i].n_pts >= 0) begin
        if (n != dir_tab[i].n_pts) begin
          $error("point count: expected %0d, got %0d", dir_tab[i].n_pts, n);
          errors++;
        end else if (n > 0 && (lead_pt.px !== dir_tab[i].fx || lead_pt.py !== dir_tab[i].fy)) begin
          $error("first point: expected (%0d,%0d), got (%0d,%0d)",
                 $signed(dir_tab[i].fx), $signed(dir_tab[i].fy),
                 $signed(lead_pt.px), $signed(lead_pt.py));
          errors++;
        end
      end
    end

    phase = 0;
    emitting_items = 0;
    while (emitting_items < RANDOM_ITEMS) begin
      if (emitting_items >= (phase + 1) * PHASE_ITEMS) begin
        phase++;
        drain_and_switch(phase);
      end
      roll = $urandom_range(99);
      if (roll < 10) begin
        // noise: either command with arbitrary fields
        it = rand_item(mcpg_pkg::cmd_t'($urandom_range(1)), $urandom_range((1 << CB) - 1));
        send_item(it, n);
      end else begin
        r = ($urandom_range(15) == 0) ? $urandom_range((1 << CB) - 1) : $urandom_range(40);
        // some circles are cut short by the next start
        limit = (roll < 25) ? $urandom_range(3) : 60;
        send_item(rand_item(mcpg_pkg::CMD_START, r), n);
        steps = 0;
        while (circle_busy && steps < limit) begin
          send_item(rand_item(mcpg_pkg::CMD_STEP, $urandom_range((1 << CB) - 1)), n);
          steps++;
        end
        if ($urandom_range(3) == 0) begin
          send_item(rand_item(mcpg_pkg::CMD_STEP, $urandom_range((1 << CB) - 1)), n);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// File: midpoint_circle_pixel_generator_top.f
hw/rtl/mcpg_pkg.sv
hw/rtl/mcpg_front.sv
hw/rtl/mcpg_queue.sv
hw/rtl/mcpg_back.sv
hw/rtl/midpoint_circle_pixel_generator_top.sv
hw/rtl/mcpg_checker.sv
test/testbench.sv
